// ===== hw/rtl/psseq_pkg.sv =====
// Shared types and constants for the pattern step sequencer.
`default_nettype none

package psseq_pkg;

    // Operation carried on the input channel's tuser.
    typedef enum logic [2:0] {
        FUNC_ADVANCE = 3'd0,
        FUNC_REWIND  = 3'd1,
        FUNC_SETPOS  = 3'd2,
        FUNC_WRITE   = 3'd3,
        FUNC_READ    = 3'd4
    } func_t;

    // Where the reported step of an operation comes from.
    typedef enum logic [1:0] {
        SRC_MEM   = 2'd0,
        SRC_INPUT = 2'd1,
        SRC_ZERO  = 2'd2
    } src_t;

    // One pattern step, 21 bits.
    typedef struct packed {
        logic              end_mark;
        logic [1:0]        transpose;
        logic              slide;
        logic              accent;
        logic [7:0]        gate;
        logic signed [7:0] pitch;
    } step_t;

    localparam int unsigned STEP_W = $bits(step_t);

    localparam logic [1:0] XPOSE_UP   = 2'd1;
    localparam logic [1:0] XPOSE_DOWN = 2'd2;

    localparam logic [7:0] OCTAVE = 8'd12;

endpackage

`default_nettype wire

// ===== hw/rtl/psseq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pattern_step_sequencer_core.sv =====
// Top level of the pattern step sequencer: pattern store, play position and result stream.
`default_nettype none

// Pattern step sequencer. Each input beat is one operation (advance, rewind,
// set position, write step, read step) selected by s_tuser, and yields exactly
// one result beat carrying the play position after the operation and the
// reported step with its octave-transposed pitch. One beat is accepted per
// clock while the result side keeps up. The accepting edge loads stage 1 and
// also the registered read of the pattern RAM; the output register is then
// loaded from stage 1 whenever it is empty or its beat is being taken, so a
// result beat waits in stage 1 while the result side stalls. With both stages
// full and m_tready low, s_tready drops until the result side drains.
// The pattern store is a STEPS-entry RAM with one valid flip-flop per entry,
// so reset makes every step read as a rest with all fields zero at once,
// without a clearing pass. Step indexes not below STEPS are ignored and
// flagged on m_tuser with all step fields zero.
module pattern_step_sequencer_core
    import psseq_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // step_index[7:0], pitch_in[15:8], gate_in[23:16], accent_in[24],
    // slide_in[25], transpose_in[27:26], end_mark_in[28], zero above
    input  wire logic [31:0] s_tdata,
    // func[2:0]
    input  wire logic [2:0]  s_tuser,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // position[3:0], pitch_out[11:4], pitch_shifted[19:12], gate_out[27:20],
    // accent_out[28], slide_out[29], transpose_out[31:30], end_mark_out[32],
    // zero above
    output      logic [39:0] m_tdata,
    // index_error[0]
    output      logic [0:0]  m_tuser
);

    localparam int PW = $clog2(STEPS);
    localparam logic [8:0]    STEPS_W  = 9'(STEPS);
    localparam logic [PW-1:0] LAST_POS = PW'(STEPS - 1);

    // Input beat fields
    logic [7:0] step_index;
    step_t      in_entry;
    func_t      func;
    logic       in_range;

    assign step_index         = s_tdata[7:0];
    assign in_entry.pitch     = s_tdata[15:8];
    assign in_entry.gate      = s_tdata[23:16];
    assign in_entry.accent    = s_tdata[24];
    assign in_entry.slide     = s_tdata[25];
    assign in_entry.transpose = s_tdata[27:26];
    assign in_entry.end_mark  = s_tdata[28];
    assign func               = func_t'(s_tuser);
    assign in_range           = ({1'b0, step_index} < STEPS_W);

    // Handshake
    logic accept;
    logic out_ready;
    logic s1_move;

    // Architectural state
    logic [PW-1:0]    play_reg, play_next;
    logic [STEPS-1:0] valid_reg, valid_next;
    logic             cur_end_reg, cur_end_next;

    // Stage 1: operation accepted, RAM read in flight
    logic          s1_valid_reg, s1_valid_next;
    src_t          s1_src_reg, s1_src_next;
    logic          s1_at_pos_reg, s1_at_pos_next;
    logic          s1_err_reg, s1_err_next;
    logic [PW-1:0] s1_pos_reg, s1_pos_next;
    step_t         s1_wentry_reg;
    logic          s1_rd_valid_reg;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [3:0]  m_pos_reg;
    step_t       m_entry_reg;
    logic [7:0]  m_shift_reg;
    logic        m_err_reg;

    // RAM
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [PW-1:0] ram_raddr;
    step_t         ram_rdata;
    logic [STEP_W-1:0] ram_rdata_raw;

    assign out_ready = !m_valid_reg || m_tready;
    assign s1_move   = s1_valid_reg && out_ready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign accept    = s_tvalid && s_tready;
    assign ram_rdata = step_t'(ram_rdata_raw);

    // End mark of the step at the current play position. While the entry of
    // the new position is still coming out of the RAM it is taken from there.
    logic cur_end;
    assign cur_end = (s1_valid_reg && s1_at_pos_reg) ?
                     (s1_rd_valid_reg && ram_rdata.end_mark) : cur_end_reg;

    // Operation decode
    always_comb begin
        play_next      = play_reg;
        valid_next     = valid_reg;
        cur_end_next   = cur_end;
        s1_src_next    = SRC_MEM;
        s1_at_pos_next = 1'b1;
        s1_err_next    = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = PW'(step_index);
        ram_raddr      = play_reg;
        if (accept) begin
            unique case (func)
                FUNC_ADVANCE: begin
                    if (cur_end || play_reg == LAST_POS) begin
                        play_next = '0;
                    end else begin
                        play_next = play_reg + PW'(1);
                    end
                    ram_raddr = play_next;
                end
                FUNC_REWIND: begin
                    play_next = '0;
                    ram_raddr = '0;
                end
                FUNC_SETPOS: begin
                    if (in_range) begin
                        play_next = PW'(step_index);
                        ram_raddr = PW'(step_index);
                    end else begin
                        s1_src_next    = SRC_ZERO;
                        s1_at_pos_next = 1'b0;
                        s1_err_next    = 1'b1;
                    end
                end
                FUNC_WRITE: begin
                    s1_at_pos_next = 1'b0;
                    if (in_range) begin
                        s1_src_next                    = SRC_INPUT;
                        ram_we                         = 1'b1;
                        valid_next[PW'(step_index)]    = 1'b1;
                        if (PW'(step_index) == play_reg) begin
                            cur_end_next = in_entry.end_mark;
                        end
                    end else begin
                        s1_src_next = SRC_ZERO;
                        s1_err_next = 1'b1;
                    end
                end
                FUNC_READ: begin
                    s1_at_pos_next = 1'b0;
                    if (in_range) begin
                        ram_raddr = PW'(step_index);
                    end else begin
                        s1_src_next = SRC_ZERO;
                        s1_err_next = 1'b1;
                    end
                end
                default: begin
                    // Unused codes report the current step unchanged.
                    ram_raddr = play_reg;
                end
            endcase
        end
    end

    always_comb begin
        s1_pos_next   = play_next;
        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        m_valid_next  = s1_move ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    psseq_ram #(
        .WIDTH (STEP_W),
        .DEPTH (STEPS)
    ) u_pattern_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_entry),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    // Reported step and its transposed pitch
    step_t      rep_entry;
    logic [7:0] rep_shift;

    always_comb begin
        case (s1_src_reg)
            SRC_MEM:   rep_entry = s1_rd_valid_reg ? ram_rdata : '0;
            SRC_INPUT: rep_entry = s1_wentry_reg;
            default:   rep_entry = '0;
        endcase
        case (rep_entry.transpose)
            XPOSE_UP:   rep_shift = rep_entry.pitch + OCTAVE;
            XPOSE_DOWN: rep_shift = rep_entry.pitch - OCTAVE;
            default:    rep_shift = rep_entry.pitch;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_reg     <= '0;
            valid_reg    <= '0;
            cur_end_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            play_reg     <= play_next;
            valid_reg    <= valid_next;
            cur_end_reg  <= cur_end_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_src_reg      <= s1_src_next;
            s1_at_pos_reg   <= s1_at_pos_next;
            s1_err_reg      <= s1_err_next;
            s1_pos_reg      <= s1_pos_next;
            s1_wentry_reg   <= in_entry;
            s1_rd_valid_reg <= valid_reg[ram_raddr];
        end
        if (s1_move) begin
            m_pos_reg   <= 4'(s1_pos_reg);
            m_entry_reg <= rep_entry;
            m_shift_reg <= rep_shift;
            m_err_reg   <= s1_err_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0,
                       m_entry_reg.end_mark,
                       m_entry_reg.transpose,
                       m_entry_reg.slide,
                       m_entry_reg.accent,
                       m_entry_reg.gate,
                       m_shift_reg,
                       m_entry_reg.pitch,
                       m_pos_reg};
    assign m_tuser  = m_err_reg;

endmodule

`default_nettype wire
